// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MPU_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MPU_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ===== design/mpu_pkg.sv =====
// ----------------------------------------------------------------------------
// mpu_pkg
// Shared types and constants of the modular power unit.
// ----------------------------------------------------------------------------
package mpu_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned MOD_W  = 31;
	localparam int unsigned CNT_W  = 7;

	localparam logic [CNT_W-1:0] BITS_WIDE   = 7'd64;
	localparam logic [CNT_W-1:0] BITS_NARROW = 7'd31;

	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

	localparam logic CMD_MOD   = 1'b0;
	localparam logic CMD_PLAIN = 1'b1;

	typedef struct packed {
		logic start;
		logic modular;
		logic wide;
	} mpu_req_t;

endpackage

// ===== design/modular_power_unit.sv =====
// ----------------------------------------------------------------------------
// modular_power_unit
// Right-to-left square-and-multiply power, modular or wrapping mod 2^64.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | cmd, base, exponent
//  out     | out_valid / out_stall| power
//  cfg     | cfg_valid / cfg_ready| cfg_data (modulus)
//
// One request at a time on a shared bit-serial multiplier, one bit per cycle.
// Modular: a base reduction first, then squares and multiplies mod the modulus.
// Plain: squares and multiplies wrap mod 2^64. One square per exponent bit
// up to the highest set bit, one multiply per set bit, a control state per
// bit and a final state; in_stall is high until the request ends.
// A finished result waits in the output register while the next request runs.
// Reset loads modulus 1000000007; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_power_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic signed [63:0]            base,
	input  logic signed [63:0]            exponent,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [63:0]            power,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpu_pkg::MOD_W-1:0]     cfg_data
);
	import mpu_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RED  = 6'b000010,
		ST_LOOP = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_SQR  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [MOD_W-1:0]  modulus_q;
	logic              cmd_q, acc_sign_q, sq_sign_q, out_valid_q;
	logic [DATA_W-1:0] e_q, acc_q, sq_q, res_q, power_q;
	mpu_req_t          req;
	logic [DATA_W-1:0] mul_a, mul_b, mul_r, base_mag;
	logic              mul_done, accept;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign base_mag  = base[63] ? (64'd0 - base) : base;

	always_comb begin
		req         = '0;
		mul_a       = sq_q;
		mul_b       = sq_q;
		req.modular = (cmd_q == CMD_MOD);
		req.wide    = (cmd_q == CMD_PLAIN);
		case (state_q)
			ST_IDLE: begin
				mul_a = 64'd1;
				mul_b = base_mag;
				if (accept && (cmd == CMD_MOD) && (modulus_q != '0)) begin
					req.start   = 1'b1;
					req.modular = 1'b1;
					req.wide    = 1'b1;
				end
			end
			ST_LOOP: begin
				if (e_q != '0) begin
					req.start = 1'b1;
					if (e_q[0]) mul_b = acc_q;
				end
			end
			ST_MUL: begin
				if (mul_done) req.start = 1'b1;
			end
			default: ;
		endcase
	end

	mpu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (mul_a),
		.b      (mul_b),
		.m      (modulus_q),
		.done   (mul_done),
		.r      (mul_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) modulus_q <= cfg_data;
			if ((state_q == ST_FIN) && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_PLAIN) state_q <= ST_LOOP;
						else if (modulus_q == '0) state_q <= ST_FIN;
						else state_q <= ST_RED;
					end
				end
				ST_RED: if (mul_done) state_q <= ST_LOOP;
				ST_LOOP: begin
					if (e_q == '0) state_q <= ST_FIN;
					else if (e_q[0]) state_q <= ST_MUL;
					else state_q <= ST_SQR;
				end
				ST_MUL: if (mul_done) state_q <= ST_SQR;
				ST_SQR: if (mul_done) state_q <= ST_LOOP;
				ST_FIN: begin
					if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q      <= cmd;
					e_q        <= exponent[63] ? '0 : exponent;
					acc_q      <= 64'd1;
					acc_sign_q <= 1'b0;
					sq_q       <= base;
					sq_sign_q  <= base[63];
					res_q      <= '0;
				end
			end
			ST_RED: if (mul_done) sq_q <= mul_r;
			ST_LOOP: begin
				if (e_q == '0) begin
					if (cmd_q == CMD_MOD && acc_sign_q) res_q <= 64'd0 - acc_q;
					else res_q <= acc_q;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					acc_q      <= mul_r;
					acc_sign_q <= acc_sign_q ^ sq_sign_q;
				end
			end
			ST_SQR: begin
				if (mul_done) begin
					sq_q      <= mul_r;
					sq_sign_q <= 1'b0;
					e_q       <= {1'b0, e_q[DATA_W-1:1]};
				end
			end
			ST_FIN: if (!out_valid_q || !out_stall) power_q <= res_q;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign power     = power_q;

	`MPU_ASSERT_NOW(a_done_busy_state,
		mul_done, (state_q == ST_RED) || (state_q == ST_MUL) || (state_q == ST_SQR))
	`MPU_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
	`MPU_ASSERT_NOW(a_sq_reduced,
		(state_q == ST_LOOP) && (cmd_q == CMD_MOD), sq_q < {33'b0, modulus_q})

endmodule

// ===== design/mpu_mul.sv =====
// ----------------------------------------------------------------------------
// mpu_mul
// Bit-serial multiplier: one multiplier bit per cycle, msb first, either
// wrapping modulo 2^64 or with interleaved reduction by the modulus.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpu_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mpu_pkg::mpu_req_t             req,
	input  logic [mpu_pkg::DATA_W-1:0]    a,
	input  logic [mpu_pkg::DATA_W-1:0]    b,
	input  logic [mpu_pkg::MOD_W-1:0]     m,
	output logic                          done,
	output logic [mpu_pkg::DATA_W-1:0]    r
);
	import mpu_pkg::*;

	logic [DATA_W-1:0] a_q, b_q, r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q, mod_q;
	logic [DATA_W-1:0] plain_nx;
	logic [33:0]       t0, t1, t2, m34, addend;

	assign m34    = {3'b0, m};
	assign addend = b_q[DATA_W-1] ? a_q[33:0] : 34'd0;
	assign t0     = {r_q[32:0], 1'b0} + addend;
	assign t1     = (t0 >= m34) ? (t0 - m34) : t0;
	assign t2     = (t1 >= m34) ? (t1 - m34) : t1;
	assign plain_nx = {r_q[DATA_W-2:0], 1'b0} + (b_q[DATA_W-1] ? a_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mod_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mod_q  <= req.modular;
				cnt_q  <= req.wide ? BITS_WIDE : BITS_NARROW;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= a;
			r_q <= '0;
			b_q <= req.wide ? b : {b[MOD_W-1:0], {(DATA_W-MOD_W){1'b0}}};
		end else if (busy_q) begin
			b_q <= {b_q[DATA_W-2:0], 1'b0};
			r_q <= mod_q ? {30'b0, t2} : plain_nx;
		end
	end

	assign done = done_q;
	assign r    = r_q;

	`MPU_ASSERT_NOW(a_mul_done_idle, done_q, !busy_q)
	`MPU_ASSERT_NEXT(a_mul_start_busy, req.start, busy_q)
	`MPU_ASSERT_NOW(a_mul_mod_range, done_q && mod_q && (m != '0), r_q < {33'b0, m})

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the power unit against a square-and-multiply predictor in both modes.
// Requests enter in bursts with gaps. Results are taken under a changing
// stall pattern. The modulus is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
	import mpu_pkg::*;

	typedef struct {
		logic        cmd;
		logic [63:0] base;
		logic [63:0] exponent;
	} power_req_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic signed [63:0] base;
	logic signed [63:0] exponent;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] power;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [MOD_W-1:0]   cfg_data;

	power_req_t       pending_reqs[$];
	logic [63:0]      expected_powers[$];
	logic [MOD_W-1:0] cur_modulus;
	int               mismatches;
	int               burst_left;
	int               gap_left;
	int               stall_mode;
	int unsigned      cycle_count;

	modular_power_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.base     (base),
		.exponent (exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.power    (power),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] predict_power(logic op, logic [63:0] b, logic [63:0] e,
			logic [MOD_W-1:0] m);
		longint      acc;
		longint      sq;
		longint      md;
		logic [63:0] wacc;
		logic [63:0] wsq;
		logic [63:0] ue;
		ue = e[63] ? 64'd0 : e;
		if (op == CMD_PLAIN) begin
			wacc = 64'd1;
			wsq = b;
			while (ue != 0) begin
				if (ue[0])
					wacc = wacc * wsq;
				wsq = wsq * wsq;
				ue = ue >> 1;
			end
			return wacc;
		end
		if (m == 0)
			return 64'd0;
		md = longint'({33'd0, m});
		acc = 1;
		sq = $signed(b) % md;
		while (ue != 0) begin
			if (ue[0])
				acc = (acc * sq) % md;
			sq = (sq * sq) % md;
			ue = ue >> 1;
		end
		return acc;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("tb_top: mismatch %s got %h want %h at cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic add_req(logic op, logic [63:0] b, logic [63:0] e);
		power_req_t r;
		r.cmd = op;
		r.base = b;
		r.exponent = e;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic add_random_reqs(int count);
		logic [63:0] b;
		logic [63:0] e;
		int          pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				b = {$urandom, $urandom};
			else if (pick < 8)
				b = 64'($urandom_range(0, 1000));
			else
				b = -64'($urandom_range(0, 1000));
			pick = $urandom_range(0, 99);
			if (pick < 85)
				e = 64'($urandom_range(0, 31));
			else if (pick < 93)
				e = 64'($urandom_range(0, 4095));
			else if (pick < 97)
				e = {1'b1, 31'($urandom), $urandom};
			else
				e = {1'b0, 31'($urandom), $urandom};
			add_req(1'($urandom_range(0, 1)), b, e);
		end
	endtask

	task automatic wait_idle();
		do begin
			while (pending_reqs.size() != 0 || expected_powers.size() != 0 || in_valid)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end while (pending_reqs.size() != 0 || expected_powers.size() != 0 || in_valid);
	endtask

	task automatic write_modulus(logic [MOD_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cur_modulus <= MODULUS_RESET;
		else if (cfg_valid && cfg_ready)
			cur_modulus <= cfg_data;
	end

	// driver: bursts of requests with random gaps
	always @(posedge clk or negedge arst_n) begin
		power_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= 1'b0;
			base <= '0;
			exponent <= '0;
			burst_left <= 4;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_powers.insert(expected_powers.size(),
					predict_power(cmd, base, exponent, cur_modulus));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					r = pending_reqs.pop_front();
					cmd <= r.cmd;
					base <= r.base;
					exponent <= r.exponent;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern and result check
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count % 97 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= 1'b1;
			endcase
			if (out_valid && !out_stall) begin
				if (expected_powers.size() == 0) begin
					report_mismatch("unexpected power", power, 64'd0);
				end else begin
					want = expected_powers.pop_front();
					if (power !== want)
						report_mismatch("power", power, want);
				end
			end
			if (cycle_count >= 80000000) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		logic [MOD_W-1:0] moduli[6];
		mismatches = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		add_req(CMD_MOD, 64'd0, 64'd0);
		add_req(CMD_PLAIN, 64'd0, 64'd0);
		add_req(CMD_MOD, 64'd2, 64'd10);
		add_req(CMD_PLAIN, 64'd3, 64'd40);
		add_req(CMD_MOD, -64'd1, 64'd3);
		add_req(CMD_PLAIN, -64'd1, 64'd3);
		add_req(CMD_MOD, -64'd7, 64'd5);
		add_req(CMD_MOD, 64'h7fff_ffff_ffff_ffff, 64'd2);
		add_req(CMD_MOD, 64'h8000_0000_0000_0000, 64'd3);
		add_req(CMD_PLAIN, 64'h8000_0000_0000_0000, 64'd1);
		add_req(CMD_PLAIN, 64'h7fff_ffff_ffff_ffff, 64'd2);
		add_req(CMD_MOD, 64'd5, -64'd1);
		add_req(CMD_PLAIN, 64'd5, 64'h8000_0000_0000_0000);
		add_req(CMD_MOD, 64'd3, 64'h7fff_ffff_ffff_ffff);
		add_req(CMD_PLAIN, 64'd3, 64'h7fff_ffff_ffff_ffff);
		add_req(CMD_MOD, 64'd1000000007, 64'd4);
		add_req(CMD_MOD, -64'd1000000008, 64'd3);
		add_req(CMD_PLAIN, 64'hffff_ffff_ffff_ffff, 64'd0);
		add_req(CMD_MOD, 64'd0, 64'd9);
		add_req(CMD_PLAIN, 64'd2, 64'd64);
		add_random_reqs(240);
		wait_idle();

		moduli[0] = 31'd1;
		moduli[1] = 31'h7fff_ffff;
		moduli[2] = 31'd0;
		moduli[3] = 31'd2;
		moduli[4] = 31'd65537;
		moduli[5] = 31'($urandom_range(3, 32'h7fff_fffe));
		foreach (moduli[i]) begin
			write_modulus(moduli[i]);
			add_req(CMD_MOD, 64'd9, 64'd0);
			add_req(CMD_MOD, -64'd9, 64'd3);
			add_random_reqs(260);
			wait_idle();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
